// ===== rtl/fwc_pkg.sv =====
package fwc_pkg;

  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned ID_BITS  = 16;
  localparam int unsigned IDX_BITS = $clog2(DEPTH);
  localparam int unsigned CNT_BITS = IDX_BITS + 1;

  localparam logic [1:0] MODE_PUT    = 2'd0;
  localparam logic [1:0] MODE_GET    = 2'd1;
  localparam logic [1:0] MODE_CANCEL = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [1:0] RD_HEAD     = 2'd0;
  localparam logic [1:0] RD_POS      = 2'd1;
  localparam logic [1:0] RD_POS_NEXT = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [ID_BITS-1:0] id_value;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [ID_BITS-1:0]  read_id;
    logic [CNT_BITS-1:0] occupancy;
  } rsp_t;

  typedef struct packed {
    logic       load;
    logic       put_do;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       get_do;
    logic       srch_adv;
    logic       set_moves;
    logic       mv_do;
    logic       cancel_done;
    logic       emit;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic search_end;
    logic match;
    logic moves_zero;
  } sts_t;

endpackage

// ===== rtl/fifo_with_cancel_by_id.sv =====
// Put goes through S_PUT, get through S_GET_RD and S_GET_WB, and a no-op straight to S_RESP.
// Cancel walks the queue from the head through a single read port: each entry compared takes
// S_SRD and S_SCMP, and each later entry moved down to close the gap takes S_MCHK and S_MWR.
// A new request is taken in the cycle the previous result strobes; the receiver cannot stall.
// Reset clears head, count and the FSM and sets tail to all ones at once; the entry memory is not cleared.
module fifo_with_cancel_by_id (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  fwc_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output fwc_pkg::rsp_t rsp_o
);
  import fwc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fwc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .mode_i (req_i.mode),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  fwc_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .id_i       (req_i.id_value),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

endmodule

// ===== rtl/fwc_ctrl.sv =====
module fwc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        mode_i,
  input  fwc_pkg::sts_t     sts_i,
  output fwc_pkg::cmd_t     cmd_o,
  output logic              busy_o
);
  import fwc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PUT    = 4'd1;
  localparam logic [3:0] S_GET_RD = 4'd2;
  localparam logic [3:0] S_GET_WB = 4'd3;
  localparam logic [3:0] S_SRD    = 4'd4;
  localparam logic [3:0] S_SCMP   = 4'd5;
  localparam logic [3:0] S_MCHK   = 4'd6;
  localparam logic [3:0] S_MWR    = 4'd7;
  localparam logic [3:0] S_RESP   = 4'd8;

  logic [3:0] state_q, state_d;
  logic [1:0] status_q, status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cmd_o    = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          status_d   = ST_OK;
          case (mode_i)
            MODE_PUT:    state_d = S_PUT;
            MODE_GET:    state_d = S_GET_RD;
            MODE_CANCEL: state_d = S_SRD;
            default:     state_d = S_RESP;
          endcase
        end
      end
      S_PUT: begin
        if (sts_i.full) begin
          status_d = ST_FULL;
        end else begin
          cmd_o.put_do = 1'b1;
        end
        state_d = S_RESP;
      end
      S_GET_RD: begin
        if (sts_i.empty) begin
          status_d = ST_EMPTY;
          state_d  = S_RESP;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_HEAD;
          state_d      = S_GET_WB;
        end
      end
      S_GET_WB: begin
        cmd_o.get_do = 1'b1;
        state_d      = S_RESP;
      end
      S_SRD: begin
        if (sts_i.search_end) begin
          status_d = ST_NOTFOUND;
          state_d  = S_RESP;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_POS;
          state_d      = S_SCMP;
        end
      end
      S_SCMP: begin
        if (sts_i.match) begin
          cmd_o.set_moves = 1'b1;
          state_d         = S_MCHK;
        end else begin
          cmd_o.srch_adv = 1'b1;
          state_d        = S_SRD;
        end
      end
      S_MCHK: begin
        if (sts_i.moves_zero) begin
          cmd_o.cancel_done = 1'b1;
          state_d           = S_RESP;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_POS_NEXT;
          state_d      = S_MWR;
        end
      end
      S_MWR: begin
        cmd_o.mv_do = 1'b1;
        state_d     = S_MCHK;
      end
      S_RESP: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cmd_o.status = status_q;
  end

endmodule

// ===== rtl/fwc_dpath.sv =====
module fwc_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [fwc_pkg::ID_BITS-1:0] id_i,
  input  fwc_pkg::cmd_t               cmd_i,
  output fwc_pkg::sts_t               sts_o,
  output logic                        rsp_valid_o,
  output fwc_pkg::rsp_t               rsp_o
);
  import fwc_pkg::*;

  logic [ID_BITS-1:0]  mem [DEPTH];
  logic [ID_BITS-1:0]  rdata_q;
  logic [ID_BITS-1:0]  id_q;
  logic [ID_BITS-1:0]  rid_q;
  logic [IDX_BITS-1:0] head_q, tail_q, pos_q;
  logic [CNT_BITS-1:0] count_q, step_q, moves_q;
  logic                valid_q;
  rsp_t                rsp_q;

  logic [IDX_BITS-1:0] rd_addr;
  logic [IDX_BITS-1:0] wr_addr;
  logic [ID_BITS-1:0]  wr_data;
  logic                wr_en;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_HEAD:     rd_addr = head_q;
      RD_POS:      rd_addr = pos_q;
      RD_POS_NEXT: rd_addr = pos_q + IDX_BITS'(1);
      default:     rd_addr = pos_q;
    endcase
  end

  assign wr_en   = cmd_i.put_do | cmd_i.mv_do;
  assign wr_addr = cmd_i.put_do ? tail_q + IDX_BITS'(1) : pos_q;
  assign wr_data = cmd_i.put_do ? id_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '1;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
      if (cmd_i.put_do) begin
        tail_q  <= tail_q + IDX_BITS'(1);
        count_q <= count_q + CNT_BITS'(1);
      end
      if (cmd_i.get_do) begin
        head_q  <= head_q + IDX_BITS'(1);
        count_q <= count_q - CNT_BITS'(1);
      end
      if (cmd_i.cancel_done) begin
        tail_q  <= tail_q - IDX_BITS'(1);
        count_q <= count_q - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q   <= id_i;
      rid_q  <= '0;
      pos_q  <= head_q;
      step_q <= '0;
    end
    if (cmd_i.get_do) begin
      rid_q <= rdata_q;
    end
    if (cmd_i.srch_adv) begin
      pos_q  <= pos_q + IDX_BITS'(1);
      step_q <= step_q + CNT_BITS'(1);
    end
    if (cmd_i.set_moves) begin
      moves_q <= count_q - step_q - CNT_BITS'(1);
    end
    if (cmd_i.mv_do) begin
      pos_q   <= pos_q + IDX_BITS'(1);
      moves_q <= moves_q - CNT_BITS'(1);
    end
    if (cmd_i.emit) begin
      rsp_q.status    <= cmd_i.status;
      rsp_q.read_id   <= rid_q;
      rsp_q.occupancy <= count_q;
    end
  end

  assign sts_o.full       = (count_q == CNT_BITS'(DEPTH));
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.search_end = (step_q >= count_q);
  assign sts_o.match      = (rdata_q == id_q);
  assign sts_o.moves_zero = (moves_q == '0);

  assign rsp_valid_o = valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== tb/fifo_cancel_checker.sv =====
module fifo_cancel_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  fwc_pkg::req_t req_i,
  input  logic          rsp_valid_i,
  input  fwc_pkg::rsp_t rsp_i,
  output int            mismatch_cnt_o,
  output int            outstanding_o
);
  import fwc_pkg::*;

  logic [ID_BITS-1:0] held_ids[$];
  rsp_t               expected_rsps[$];
  int                 mismatch_cnt = 0;

  function automatic rsp_t apply_fifo_op(input req_t r);
    rsp_t o;
    int   hit;
    o        = '0;
    o.status = ST_OK;
    hit      = -1;
    case (r.mode)
      MODE_PUT: begin
        if (held_ids.size() >= DEPTH) o.status = ST_FULL;
        else held_ids.push_back(r.id_value);
      end
      MODE_GET: begin
        if (held_ids.size() == 0) o.status = ST_EMPTY;
        else o.read_id = held_ids.pop_front();
      end
      MODE_CANCEL: begin
        foreach (held_ids[i]) begin
          if (hit < 0 && held_ids[i] == r.id_value) hit = i;
        end
        if (hit < 0) o.status = ST_NOTFOUND;
        else held_ids.delete(hit);
      end
      default: ;
    endcase
    o.occupancy = CNT_BITS'(held_ids.size());
    return o;
  endfunction

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (rsp_valid_i) begin
        if (expected_rsps.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result with none pending: status %0d id %h occ %0d",
                     $realtime, rsp_i.status, rsp_i.read_id, rsp_i.occupancy);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_i.status !== want.status || rsp_i.read_id !== want.read_id ||
              rsp_i.occupancy !== want.occupancy) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: mismatch exp status %0d id %h occ %0d, got status %0d id %h occ %0d",
                       $realtime, want.status, want.read_id, want.occupancy,
                       rsp_i.status, rsp_i.read_id, rsp_i.occupancy);
          end
        end
      end
      if (start && !busy) expected_rsps.push_back(apply_fifo_op(req_i));
    end
    mismatch_cnt_o <= mismatch_cnt;
    outstanding_o  <= expected_rsps.size();
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import fwc_pkg::*;

  localparam logic [1:0] MODE_NOP    = 2'd3;
  localparam int         QUIET_LIMIT = 20000;
  localparam int         HOVER_ITEMS = 100;
  localparam int         MIN_ITEMS   = 1400;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req    = '0;
  logic busy;
  logic rsp_valid;
  rsp_t rsp;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  int sent         = 0;
  int burst_left   = 0;
  int last_occ     = 0;
  int peak_occ     = 0;
  int op_count[4];
  int status_count[4];
  logic [ID_BITS-1:0] id_pool[16];

  fifo_with_cancel_by_id uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp)
  );

  fifo_cancel_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .rsp_valid_i    (rsp_valid),
    .rsp_i          (rsp),
    .mismatch_cnt_o (mismatches),
    .outstanding_o  (outstanding)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rsp_valid) begin
      last_occ                   <= int'(rsp.occupancy);
      status_count[rsp.status]   <= status_count[rsp.status] + 1;
      if (int'(rsp.occupancy) > peak_occ) peak_occ <= int'(rsp.occupancy);
    end
    if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] mode, input logic [ID_BITS-1:0] id);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 18);
      if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= '{mode: mode, id_value: id};
    op_count[mode]++;
    sent++;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  function automatic logic [ID_BITS-1:0] pick_id();
    if ($urandom_range(0, 3) != 0) return id_pool[$urandom_range(0, 15)];
    return ID_BITS'($urandom);
  endfunction

  task automatic random_req(input int w_put, input int w_get, input int w_cancel);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < w_put) send_req(MODE_PUT, pick_id());
    else if (roll < w_put + w_get) send_req(MODE_GET, ID_BITS'($urandom));
    else if (roll < w_put + w_get + w_cancel) send_req(MODE_CANCEL, pick_id());
    else send_req(MODE_NOP, ID_BITS'($urandom));
    if ($urandom_range(0, 63) == 0) settle();
  endtask

  initial begin
    foreach (id_pool[i]) id_pool[i] = ID_BITS'($urandom);
    id_pool[0] = '0;
    id_pool[1] = '1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(MODE_GET,    16'h0000);
    send_req(MODE_CANCEL, 16'h1234);
    send_req(MODE_NOP,    16'h0000);
    send_req(MODE_PUT,    16'h0000);
    send_req(MODE_PUT,    16'hFFFF);
    send_req(MODE_PUT,    16'h5A5A);
    send_req(MODE_PUT,    16'hFFFF);
    send_req(MODE_PUT,    16'hA5A5);
    send_req(MODE_CANCEL, 16'hFFFF);
    send_req(MODE_CANCEL, 16'h7777);
    send_req(MODE_NOP,    16'hFFFF);
    send_req(MODE_CANCEL, 16'hA5A5);
    send_req(MODE_CANCEL, 16'h0000);
    send_req(MODE_GET,    16'hFFFF);
    send_req(MODE_GET,    16'h0000);
    send_req(MODE_GET,    16'h0000);
    send_req(MODE_PUT,    16'h8001);
    send_req(MODE_CANCEL, 16'h8001);
    send_req(MODE_GET,    16'h0000);
    settle();

    for (int n = 0; n < HOVER_ITEMS; n++) begin
      if (last_occ > 24) random_req(20, 45, 30);
      else random_req(35, 30, 30);
    end
    settle();

    while (last_occ < DEPTH) random_req(97, 1, 2);
    repeat (12) random_req(90, 4, 5);
    settle();
    while (sent < MIN_ITEMS) random_req(5, 88, 6);
    repeat (4) random_req(0, 100, 0);

    settle();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d requests: %0d put, %0d get, %0d cancel, %0d no-op; peak occupancy %0d.",
             sent, op_count[MODE_PUT], op_count[MODE_GET], op_count[MODE_CANCEL],
             op_count[MODE_NOP], peak_occ);
    $display("Statuses seen: %0d ok, %0d full drop, %0d empty get, %0d cancel miss.",
             status_count[ST_OK], status_count[ST_FULL], status_count[ST_EMPTY],
             status_count[ST_NOTFOUND]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
